>>> hw/rtl/eye_opening_measure_assert.svh
// Assertion macros for the eye opening measurement block.
// Included by eye_opening_measure.sv; depends on nothing else.
`ifndef EYE_OPENING_MEASURE_ASSERT_SVH
`define EYE_OPENING_MEASURE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define EOM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define EOM_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/eom_pkg.sv
// Package for the eye opening measurement block: field widths, register map and defaults.
// Used by eye_opening_measure.sv; depends on nothing else.
package eom_pkg;

    localparam int CFG_W              = 9;
    localparam int HIT_W              = 32;
    localparam int HEIGHT_W           = 9;
    localparam int WIDTH_W            = 9;
    localparam int JITTER_W           = 8;
    localparam int APB_ADDR_W         = 3;
    localparam int APB_DATA_W         = 32;
    localparam int REG_SEL_BIT        = 2;
    localparam int DEF_MAX_TIME_BINS  = 256;
    localparam int DEF_MAX_VOLT_BINS  = 256;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    typedef enum logic {
        REG_TIME_BINS = 1'b0,
        REG_VOLT_BINS = 1'b1
    } cfg_reg_t;

endpackage

>>> hw/rtl/eye_opening_measure.sv
// Eye opening measurement: height, width and jitter of an eye-diagram hit grid.
// Depends on eom_pkg and on the assertion macros in eye_opening_measure_assert.svh.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_valid/s_ready    s_hit_count, one grid cell per transaction
//   m_        out        m_valid/m_ready    m_height_bins, m_width_bins, m_jitter_bins
//   APB       in/out     psel/penable       time_bins_used at 0x0, volt_bins_used at 0x4
//
// One cell is taken per cycle unless a grid's last cell waits on a stalled result; a
// cell passes the input register and updates the run counters as it leaves it. The result
// is loaded as the grid's last cell leaves and sits in the output register until taken.
// A stalled result holds back only the last cell of the next grid.
// Reset and any register write restart the grid.
`include "eye_opening_measure_assert.svh"

module eye_opening_measure #(
    parameter int MAX_TIME_BINS = eom_pkg::DEF_MAX_TIME_BINS,
    parameter int MAX_VOLT_BINS = eom_pkg::DEF_MAX_VOLT_BINS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [eom_pkg::HIT_W-1:0]         s_hit_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [eom_pkg::HEIGHT_W-1:0]      m_height_bins,
    output logic [eom_pkg::WIDTH_W-1:0]       m_width_bins,
    output logic [eom_pkg::JITTER_W-1:0]      m_jitter_bins,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [eom_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [eom_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [eom_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import eom_pkg::*;

    localparam int TRUN_W = $clog2(MAX_TIME_BINS + 1);
    localparam int VRUN_W = $clog2(MAX_VOLT_BINS + 1);
    localparam int TPOS_W = (MAX_TIME_BINS > 1) ? $clog2(MAX_TIME_BINS) : 1;
    localparam int VPOS_W = (MAX_VOLT_BINS > 1) ? $clog2(MAX_VOLT_BINS) : 1;
    localparam int TCMP_W = (CFG_W > TRUN_W) ? CFG_W : TRUN_W;
    localparam int VCMP_W = (CFG_W > VRUN_W) ? CFG_W : VRUN_W;
    localparam int OEXT_A = (TRUN_W > VRUN_W) ? TRUN_W : VRUN_W;
    localparam int OEXT_W = (OEXT_A > HEIGHT_W) ? OEXT_A : HEIGHT_W;

    logic [CFG_W-1:0]  time_cfg_reg;
    logic [CFG_W-1:0]  volt_cfg_reg;
    logic              cfg_write;

    logic              in_valid_reg;
    logic              in_empty_reg;

    logic [TPOS_W-1:0] time_pos_reg, time_pos_next;
    logic [VPOS_W-1:0] volt_pos_reg, volt_pos_next;
    logic [VRUN_W-1:0] col_run_reg, col_run_next;
    logic [VRUN_W-1:0] col_long_reg, col_long_next;
    logic [VRUN_W-1:0] centre_min_reg, centre_min_next;
    logic              closed_seen_reg, closed_seen_next;
    logic [TRUN_W-1:0] row_run_reg, row_run_next;
    logic [TRUN_W-1:0] row_long_reg, row_long_next;

    logic                m_valid_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  width_reg;
    logic [JITTER_W-1:0] jitter_reg;

    logic [TCMP_W-1:0] time_cfg_ext, t_eff_ext;
    logic [VCMP_W-1:0] volt_cfg_ext, v_eff_ext;
    logic [TRUN_W-1:0] t_eff, t_half, t_lo, t_hi, t_pos_ext;
    logic [VRUN_W-1:0] v_eff, v_pos_ext;
    logic              last_v, last_t, is_final, is_centre, row_mid, adv;

    logic [VRUN_W-1:0] col_run_upd, col_long_upd, final_col, centre_min_upd;
    logic              closed_upd;
    logic [TRUN_W-1:0] row_run_upd, row_long_upd, width_val, jitter_val;
    logic [VRUN_W-1:0] height_val;
    logic [OEXT_W-1:0] height_ext, width_ext, jitter_ext;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_cfg_reg <= CFG_RESET;
            volt_cfg_reg <= CFG_RESET;
        end else if (cfg_write) begin
            unique case (cfg_reg_t'(paddr[REG_SEL_BIT]))
                REG_TIME_BINS: time_cfg_reg <= pwdata[CFG_W-1:0];
                REG_VOLT_BINS: volt_cfg_reg <= pwdata[CFG_W-1:0];
                default:       time_cfg_reg <= time_cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_reg_t'(paddr[REG_SEL_BIT]))
            REG_TIME_BINS: prdata = APB_DATA_W'(time_cfg_reg);
            REG_VOLT_BINS: prdata = APB_DATA_W'(volt_cfg_reg);
            default:       prdata = '0;
        endcase
    end

    // Effective grid size: zero acts as one, large values saturate.
    always_comb begin
        time_cfg_ext = TCMP_W'(time_cfg_reg);
        volt_cfg_ext = VCMP_W'(volt_cfg_reg);
        if (time_cfg_reg == '0) begin
            t_eff_ext = TCMP_W'(1);
        end else if (time_cfg_ext > TCMP_W'(MAX_TIME_BINS)) begin
            t_eff_ext = TCMP_W'(MAX_TIME_BINS);
        end else begin
            t_eff_ext = time_cfg_ext;
        end
        if (volt_cfg_reg == '0) begin
            v_eff_ext = VCMP_W'(1);
        end else if (volt_cfg_ext > VCMP_W'(MAX_VOLT_BINS)) begin
            v_eff_ext = VCMP_W'(MAX_VOLT_BINS);
        end else begin
            v_eff_ext = volt_cfg_ext;
        end
    end

    assign t_eff     = t_eff_ext[TRUN_W-1:0];
    assign v_eff     = v_eff_ext[VRUN_W-1:0];
    assign t_pos_ext = TRUN_W'(time_pos_reg);
    assign v_pos_ext = VRUN_W'(volt_pos_reg);
    assign t_half    = t_eff >> 1;
    assign t_lo      = (t_half == '0) ? '0 : t_half - TRUN_W'(1);
    assign t_hi      = ((t_half + TRUN_W'(1)) > (t_eff - TRUN_W'(1))) ?
                       (t_eff - TRUN_W'(1)) : (t_half + TRUN_W'(1));
    assign is_centre = (t_pos_ext >= t_lo) && (t_pos_ext <= t_hi);
    assign last_v    = v_pos_ext >= (v_eff - VRUN_W'(1));
    assign last_t    = t_pos_ext >= (t_eff - TRUN_W'(1));
    assign row_mid   = v_pos_ext == (v_eff >> 1);
    assign is_final  = last_v && last_t;

    // Input register.
    assign adv     = in_valid_reg && (!is_final || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_empty_reg <= (s_hit_count == '0);
        end
    end

    // Run tracking for the cell leaving the input register.
    always_comb begin
        if (in_empty_reg) begin
            col_run_upd  = col_run_reg + VRUN_W'(1);
            col_long_upd = col_long_reg;
        end else begin
            col_run_upd  = '0;
            col_long_upd = (col_run_reg > col_long_reg) ? col_run_reg : col_long_reg;
        end
        row_run_upd  = row_run_reg;
        row_long_upd = row_long_reg;
        if (row_mid) begin
            if (in_empty_reg) begin
                row_run_upd = row_run_reg + TRUN_W'(1);
            end else begin
                row_run_upd  = '0;
                row_long_upd = (row_run_reg > row_long_reg) ? row_run_reg : row_long_reg;
            end
        end
        final_col      = (col_run_upd > col_long_upd) ? col_run_upd : col_long_upd;
        closed_upd     = closed_seen_reg;
        centre_min_upd = centre_min_reg;
        if (is_centre) begin
            if (final_col == '0) begin
                closed_upd = 1'b1;
            end else if (final_col < centre_min_reg) begin
                centre_min_upd = final_col;
            end
        end
        width_val  = (row_run_upd > row_long_upd) ? row_run_upd : row_long_upd;
        height_val = closed_upd ? '0 : centre_min_upd;
        jitter_val = ((width_val != '0) && (width_val < t_eff)) ? (t_eff - width_val) : '0;
        height_ext = OEXT_W'(height_val);
        width_ext  = OEXT_W'(width_val);
        jitter_ext = OEXT_W'(jitter_val);
    end

    always_comb begin
        time_pos_next    = time_pos_reg;
        volt_pos_next    = volt_pos_reg;
        col_run_next     = col_run_reg;
        col_long_next    = col_long_reg;
        centre_min_next  = centre_min_reg;
        closed_seen_next = closed_seen_reg;
        row_run_next     = row_run_reg;
        row_long_next    = row_long_reg;
        if (cfg_write || (adv && is_final)) begin
            time_pos_next    = '0;
            volt_pos_next    = '0;
            col_run_next     = '0;
            col_long_next    = '0;
            centre_min_next  = '1;
            closed_seen_next = 1'b0;
            row_run_next     = '0;
            row_long_next    = '0;
        end else if (adv) begin
            row_run_next  = row_run_upd;
            row_long_next = row_long_upd;
            if (!last_v) begin
                volt_pos_next = volt_pos_reg + VPOS_W'(1);
                col_run_next  = col_run_upd;
                col_long_next = col_long_upd;
            end else begin
                volt_pos_next    = '0;
                col_run_next     = '0;
                col_long_next    = '0;
                centre_min_next  = centre_min_upd;
                closed_seen_next = closed_upd;
                time_pos_next    = time_pos_reg + TPOS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_pos_reg    <= '0;
            volt_pos_reg    <= '0;
            col_run_reg     <= '0;
            col_long_reg    <= '0;
            centre_min_reg  <= '1;
            closed_seen_reg <= 1'b0;
            row_run_reg     <= '0;
            row_long_reg    <= '0;
        end else begin
            time_pos_reg    <= time_pos_next;
            volt_pos_reg    <= volt_pos_next;
            col_run_reg     <= col_run_next;
            col_long_reg    <= col_long_next;
            centre_min_reg  <= centre_min_next;
            closed_seen_reg <= closed_seen_next;
            row_run_reg     <= row_run_next;
            row_long_reg    <= row_long_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && is_final) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && is_final) begin
            height_reg <= height_ext[HEIGHT_W-1:0];
            width_reg  <= width_ext[WIDTH_W-1:0];
            jitter_reg <= jitter_ext[JITTER_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_height_bins = height_reg;
    assign m_width_bins  = width_reg;
    assign m_jitter_bins = jitter_reg;

    `EOM_ASSERT_IMP(a_result_from_last_cell, aclk, aresetn, $rose(m_valid_reg), $past(adv && is_final), "result appeared without a final cell")
    `EOM_ASSERT_NXT(a_cell_held, aclk, aresetn, in_valid_reg && !adv, in_valid_reg && $stable(in_empty_reg), "stalled cell was lost")
    `EOM_ASSERT_IMP(a_position_in_grid, aclk, aresetn, 1'b1, (t_pos_ext < t_eff) && (v_pos_ext < v_eff), "grid position outside the grid")
    `EOM_ASSERT_NXT(a_result_held, aclk, aresetn, m_valid_reg && !m_ready, m_valid_reg && $stable(height_reg) && $stable(width_reg), "unaccepted result changed")

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for eye_opening_measure: streams hit-count grids on s_, sets the
// grid size over APB and compares every opening result on m_ with a predicted or directed value.
// Depends on eom_pkg and the eye_opening_measure RTL.
module testbench;
    import eom_pkg::*;

    localparam int CELL_TARGET   = 1750;
    localparam int MAX_GAP       = 13;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [HEIGHT_W-1:0] height;
        logic [WIDTH_W-1:0]  width;
        logic [JITTER_W-1:0] jitter;
    } opening_t;

    typedef struct {
        bit               reconfig;
        logic [CFG_W-1:0] time_cfg;
        logic [CFG_W-1:0] volt_cfg;
        logic [HIT_W-1:0] hit;
        bit               known;
        opening_t         opening;
    } grid_cell_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [HIT_W-1:0]      s_hit_count;
    logic                  m_valid;
    logic                  m_ready;
    logic [HEIGHT_W-1:0]   m_height_bins;
    logic [WIDTH_W-1:0]    m_width_bins;
    logic [JITTER_W-1:0]   m_jitter_bins;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    eye_opening_measure dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_hit_count   (s_hit_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_height_bins (m_height_bins),
        .m_width_bins  (m_width_bins),
        .m_jitter_bins (m_jitter_bins),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    logic [CFG_W-1:0] time_bins_cfg;
    logic [CFG_W-1:0] volt_bins_cfg;
    logic [7:0]       time_pos;
    logic [7:0]       volt_pos;
    logic [8:0]       col_run;
    logic [8:0]       col_best;
    logic [8:0]       centre_min;
    bit               centre_closed;
    logic [8:0]       row_run;
    logic [8:0]       row_best;

    opening_t    pending_openings[$];
    int unsigned cells_sent;
    int unsigned mismatches;
    int unsigned cycle_count;
    bit          no_gaps;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned bins_in_use(logic [CFG_W-1:0] r, int unsigned limit);
        if (r == 0) return 1;
        return (r > limit) ? limit : r;
    endfunction

    function automatic int unsigned grid_size();
        return bins_in_use(time_bins_cfg, DEF_MAX_TIME_BINS) *
               bins_in_use(volt_bins_cfg, DEF_MAX_VOLT_BINS);
    endfunction

    function automatic void clear_grid();
        time_pos      = '0;
        volt_pos      = '0;
        col_run       = '0;
        col_best      = '0;
        centre_min    = '1;
        centre_closed = 1'b0;
        row_run       = '0;
        row_best      = '0;
    endfunction

    // Advances the grid by one cell; returns 1 when the cell closes the grid.
    function automatic bit absorb_cell(input logic [HIT_W-1:0] hit, output opening_t res);
        int unsigned nt;
        int unsigned nv;
        int unsigned mid;
        int unsigned lo;
        int unsigned hi;
        logic [8:0]  col_final;
        logic [8:0]  width;
        bit          empty;
        nt    = bins_in_use(time_bins_cfg, DEF_MAX_TIME_BINS);
        nv    = bins_in_use(volt_bins_cfg, DEF_MAX_VOLT_BINS);
        res   = '{default: '0};
        empty = (hit == 0);
        if (empty) begin
            col_run++;
        end else begin
            if (col_run > col_best) col_best = col_run;
            col_run = '0;
        end
        if (volt_pos == nv / 2) begin
            if (empty) begin
                row_run++;
            end else begin
                if (row_run > row_best) row_best = row_run;
                row_run = '0;
            end
        end
        if (volt_pos < nv - 1) begin
            volt_pos++;
            return 1'b0;
        end
        col_final = (col_run > col_best) ? col_run : col_best;
        mid = nt / 2;
        lo  = (mid == 0) ? 0 : mid - 1;
        hi  = (mid + 1 > nt - 1) ? nt - 1 : mid + 1;
        if (time_pos >= lo && time_pos <= hi) begin
            if (col_final == 0) centre_closed = 1'b1;
            else if (col_final < centre_min) centre_min = col_final;
        end
        col_run  = '0;
        col_best = '0;
        volt_pos = '0;
        if (time_pos < nt - 1) begin
            time_pos++;
            return 1'b0;
        end
        width      = (row_run > row_best) ? row_run : row_best;
        res.height = centre_closed ? '0 : centre_min;
        res.width  = width;
        res.jitter = (width > 0 && width < nt) ? JITTER_W'(nt - width) : '0;
        clear_grid();
        return 1'b1;
    endfunction

    function automatic int unsigned draw_gap();
        return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [HIT_W-1:0] hit_value();
        logic [HIT_W-1:0] x;
        case ($urandom_range(0, 3))
            0: x = '1;
            1: x = HIT_W'(1) << $urandom_range(0, HIT_W - 1);
            default: begin
                x = $urandom;
                if (x == 0) x = 1;
            end
        endcase
        return x;
    endfunction

    function automatic grid_cell_t directed_cell(bit reconfig, logic [CFG_W-1:0] t_cfg,
                                                 logic [CFG_W-1:0] v_cfg,
                                                 logic [HIT_W-1:0] hit, bit known = 1'b0,
                                                 int h = 0, int w = 0, int j = 0);
        grid_cell_t c;
        c.reconfig       = reconfig;
        c.time_cfg       = t_cfg;
        c.volt_cfg       = v_cfg;
        c.hit            = hit;
        c.known          = known;
        c.opening.height = HEIGHT_W'(h);
        c.opening.width  = WIDTH_W'(w);
        c.opening.jitter = JITTER_W'(j);
        return c;
    endfunction

    task automatic send_cell(input logic [HIT_W-1:0] hit, input bit known,
                             input opening_t typed);
        int unsigned gap;
        opening_t    predicted;
        gap = draw_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid     = 1'b0;
            s_hit_count = $urandom;
            repeat (gap) @(negedge aclk);
        end
        s_valid     = 1'b1;
        s_hit_count = hit;
        do @(posedge aclk); while (!s_ready);
        cells_sent++;
        if (absorb_cell(hit, predicted)) pending_openings.push_back(known ? typed : predicted);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] val);
        logic [APB_DATA_W-1:0] word;
        word = $urandom;
        word[CFG_W-1:0] = val;
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = APB_ADDR_W'(int'(r) << REG_SEL_BIT);
        pwdata  = word;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        if (r == REG_TIME_BINS) time_bins_cfg = val;
        else volt_bins_cfg = val;
        clear_grid();
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        if (prdata !== APB_DATA_W'(val)) begin
            $error("prdata: expected %0d, actual %0d", val, prdata);
            mismatches++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Waits until the block is idle, then sets a new grid size, which restarts the grid.
    task automatic set_grid(input logic [CFG_W-1:0] t_cfg, input logic [CFG_W-1:0] v_cfg);
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_openings.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        write_reg(REG_TIME_BINS, t_cfg);
        write_reg(REG_VOLT_BINS, v_cfg);
    endtask

    task automatic stream_grid(input int unsigned n_cells);
        int unsigned nt;
        int unsigned nv;
        int unsigned shape;
        int unsigned pzero;
        int unsigned tlo;
        int unsigned thi;
        int unsigned vlo;
        int unsigned vhi;
        int unsigned sent;
        bit          is_open;
        bit          in_window;
        opening_t    blank;
        blank = '{default: '0};
        nt    = bins_in_use(time_bins_cfg, DEF_MAX_TIME_BINS);
        nv    = bins_in_use(volt_bins_cfg, DEF_MAX_VOLT_BINS);
        shape = $urandom_range(0, 3);
        pzero = $urandom_range(0, 100);
        tlo   = $urandom_range(0, nt - 1);
        thi   = $urandom_range(tlo, nt - 1);
        vlo   = $urandom_range(0, nv - 1);
        vhi   = $urandom_range(vlo, nv - 1);
        sent  = 0;
        for (int unsigned t = 0; t < nt && sent < n_cells; t++) begin
            for (int unsigned v = 0; v < nv && sent < n_cells; v++) begin
                in_window = (t >= tlo && t <= thi && v >= vlo && v <= vhi);
                case (shape) inside
                    0: is_open = ($urandom_range(1, 100) <= pzero);
                    1, 2: is_open = in_window ? ($urandom_range(0, 19) != 0)
                                              : ($urandom_range(0, 9) == 0);
                    default: is_open = 1'b1;
                endcase
                send_cell(is_open ? '0 : hit_value(), 1'b0, blank);
                sent++;
            end
        end
    endtask

    initial begin : result_sink
        int unsigned hold;
        hold    = 0;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold != 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
                @(posedge aclk);
                if (m_valid) hold = draw_gap();
            end
        end
    end

    always @(posedge aclk) begin
        opening_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_openings.size() == 0) begin
                $error("m_ transaction with no result expected: height %0d width %0d jitter %0d",
                       m_height_bins, m_width_bins, m_jitter_bins);
                mismatches++;
            end else begin
                exp = pending_openings.pop_front();
                if (m_height_bins !== exp.height) begin
                    $error("height_bins: expected %0d, actual %0d", exp.height, m_height_bins);
                    mismatches++;
                end
                if (m_width_bins !== exp.width) begin
                    $error("width_bins: expected %0d, actual %0d", exp.width, m_width_bins);
                    mismatches++;
                end
                if (m_jitter_bins !== exp.jitter) begin
                    $error("jitter_bins: expected %0d, actual %0d", exp.jitter, m_jitter_bins);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        grid_cell_t       directed[$];
        logic [CFG_W-1:0] t_cfg;
        logic [CFG_W-1:0] v_cfg;
        int unsigned      full;
        int unsigned      grids;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_hit_count   = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cells_sent    = 0;
        mismatches    = 0;
        cycle_count   = 0;
        no_gaps       = 1'b0;
        time_bins_cfg = CFG_RESET;
        volt_bins_cfg = CFG_RESET;
        clear_grid();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // A zero register acts as one bin.
        directed.push_back(directed_cell(1'b1, 9'd0, 9'd1, 32'h0000_0000, 1'b1, 1, 1, 0));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'hFFFF_FFFF, 1'b1, 0, 0, 0));
        directed.push_back(directed_cell(1'b1, 9'd2, 9'd0, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h8000_0000, 1'b1, 0, 1, 1));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0001));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000, 1'b1, 0, 1, 1));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000, 1'b1, 1, 2, 0));
        // A grid cut short by a register write must leave no trace in the next one.
        directed.push_back(directed_cell(1'b1, 9'd3, 9'd2, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0100));
        directed.push_back(directed_cell(1'b1, 9'd3, 9'd2, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0005));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0000));
        directed.push_back(directed_cell(1'b0, 9'd0, 9'd0, 32'h0000_0007, 1'b1, 1, 2, 1));

        foreach (directed[i]) begin
            if (directed[i].reconfig) set_grid(directed[i].time_cfg, directed[i].volt_cfg);
            send_cell(directed[i].hit, directed[i].known, directed[i].opening);
        end

        set_grid(9'd256, 9'd1);
        stream_grid(grid_size());
        set_grid(9'd0, 9'd511);
        stream_grid(grid_size());

        while (cells_sent < CELL_TARGET) begin
            no_gaps = ($urandom_range(0, 4) == 0);
            case ($urandom_range(0, 15))
                0: begin
                    t_cfg = CFG_W'($urandom_range(256, 511));
                    v_cfg = CFG_W'($urandom_range(0, 2));
                end
                1: begin
                    t_cfg = CFG_W'($urandom_range(0, 2));
                    v_cfg = CFG_W'($urandom_range(256, 511));
                end
                2: begin
                    t_cfg = '0;
                    v_cfg = CFG_W'($urandom_range(0, 12));
                end
                default: begin
                    t_cfg = CFG_W'($urandom_range(1, 12));
                    v_cfg = CFG_W'($urandom_range(1, 12));
                end
            endcase
            set_grid(t_cfg, v_cfg);
            full  = grid_size();
            grids = (full > 64) ? 1 : $urandom_range(1, 4);
            repeat (grids) stream_grid(full);
            if (full > 1 && $urandom_range(0, 3) == 0) stream_grid($urandom_range(1, full - 1));
        end

        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_openings.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
